// File: rtl/core/bpl_pkg.sv
// Shared types and constants of the buffer pool slot manager.
package bpl_pkg;

    localparam int ID_W   = 32;
    localparam int PIN_W  = 16;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 4;
    localparam int CAP_W  = 5;

    localparam logic [PIN_W-1:0] PIN_MAX   = {PIN_W{1'b1}};
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_FIX   = 1'b0;
    localparam logic ACT_UNFIX = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_HIT        = 3'd0,
        ST_LOADED     = 3'd1,
        ST_POOL_FULL  = 3'd2,
        ST_UNFIXED    = 3'd3,
        ST_NOT_CACHED = 3'd4,
        ST_NO_PINS    = 3'd5,
        ST_PIN_OVF    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EVRD,
        S_EVTAG,
        S_RMV,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [ID_W-1:0]   evicted_id;
        logic [PIN_W-1:0]  pin_count;
    } rsp_t;

endpackage

// File: rtl/core/bpl_req_if.sv
// Request channel: fix or unfix of one block id.
interface bpl_req_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [bpl_pkg::ID_W-1:0]  blk_id;

    modport source (output valid, output action, output blk_id, input ready);
    modport sink   (input valid, input action, input blk_id, output ready);
endinterface

// File: rtl/core/bpl_rsp_if.sv
// Response channel: outcome of one request.
interface bpl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bpl_pkg::STAT_W-1:0]  status;
    logic [bpl_pkg::SLOT_W-1:0]  slot;
    logic                        evicted;
    logic [bpl_pkg::ID_W-1:0]    evicted_id;
    logic [bpl_pkg::PIN_W-1:0]   pin_count;

    modport source (output valid, output status, output slot, output evicted,
                    output evicted_id, output pin_count, input ready);
    modport sink   (input valid, input status, input slot, input evicted,
                    input evicted_id, input pin_count, output ready);
endinterface

// File: rtl/core/bpl_slot_store.sv
// Slot memory: tag and pin count per slot, plus per-slot valid flags.
module bpl_slot_store #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic                          set_valid,
    input  logic [IDX_W-1:0]              waddr,
    input  logic [bpl_pkg::ID_W-1:0]      wtag,
    input  logic [bpl_pkg::PIN_W-1:0]     wpins,
    input  logic [IDX_W-1:0]              raddr,
    output logic                          rvalid,
    output logic [bpl_pkg::ID_W-1:0]      rtag,
    output logic [bpl_pkg::PIN_W-1:0]     rpins
);

    logic [bpl_pkg::ID_W+bpl_pkg::PIN_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0]                        valid_reg;
    logic [bpl_pkg::ID_W+bpl_pkg::PIN_W-1:0] rdata_reg;
    logic                                    rvalid_reg;

    // Write tag and pins, read registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wtag, wpins};
        end
        rdata_reg <= mem[raddr];
    end

    // Mark slots in use; a slot never leaves use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we && set_valid)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rvalid = rvalid_reg;
    assign rtag   = rdata_reg[bpl_pkg::ID_W+bpl_pkg::PIN_W-1:bpl_pkg::PIN_W];
    assign rpins  = rdata_reg[bpl_pkg::PIN_W-1:0];

endmodule

// File: rtl/core/bpl_order_store.sv
// Unpinned order memory: slot indexes, oldest unfix at the head.
module bpl_order_store #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [IDX_W-1:0] wdata,
    input  logic [IDX_W-1:0] raddr,
    output logic [IDX_W-1:0] rdata
);

    logic [IDX_W-1:0] mem [SLOTS];
    logic [IDX_W-1:0] rdata_reg;

    // Write one entry, read registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/bpl_ctrl.sv
// Request sequencer: tag scan, decision, order compaction and write-back.
module bpl_ctrl #(
    parameter int SLOTS = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_action,
    input  logic [bpl_pkg::ID_W-1:0]      req_blk_id,
    output logic                          req_ready,
    input  logic                          cfg_we,
    input  logic [bpl_pkg::CAP_W-1:0]     cfg_wdata,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bpl_pkg::rsp_t                 res,
    output logic                          sm_we,
    output logic                          sm_set_valid,
    output logic [IDX_W-1:0]              sm_waddr,
    output logic [bpl_pkg::ID_W-1:0]      sm_wtag,
    output logic [bpl_pkg::PIN_W-1:0]     sm_wpins,
    output logic [IDX_W-1:0]              sm_raddr,
    input  logic                          sm_rvalid,
    input  logic [bpl_pkg::ID_W-1:0]      sm_rtag,
    input  logic [bpl_pkg::PIN_W-1:0]     sm_rpins,
    output logic                          om_we,
    output logic [IDX_W-1:0]              om_waddr,
    output logic [IDX_W-1:0]              om_wdata,
    output logic [IDX_W-1:0]              om_raddr,
    input  logic [IDX_W-1:0]              om_rdata
);

    localparam int CMP_W = (CNT_W > bpl_pkg::CAP_W) ? CNT_W : bpl_pkg::CAP_W;
    localparam logic [CNT_W-1:0] SLOTS_C   = CNT_W'(SLOTS);
    localparam logic [CMP_W-1:0] SLOTS_CMP = CMP_W'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);

    bpl_pkg::state_t              state_reg, state_next;
    logic                         action_reg, action_next;
    logic [bpl_pkg::ID_W-1:0]     id_reg, id_next;
    logic [CNT_W-1:0]             scan_addr_reg, scan_addr_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                         hit_reg, hit_next;
    logic [bpl_pkg::PIN_W-1:0]    hit_pins_reg, hit_pins_next;
    logic                         free_found_reg, free_found_next;
    logic [IDX_W-1:0]             free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]             tgt_reg, tgt_next;
    logic                         ev_reg, ev_next;
    logic [bpl_pkg::ID_W-1:0]     evid_reg, evid_next;
    logic                         load_free_reg, load_free_next;
    logic [bpl_pkg::PIN_W-1:0]    new_pins_reg, new_pins_next;
    logic [CNT_W-1:0]             rm_i_reg, rm_i_next;
    logic [CNT_W-1:0]             rm_j_reg, rm_j_next;
    logic                         rm_pend_reg, rm_pend_next;
    logic [CNT_W-1:0]             unpin_cnt_reg, unpin_cnt_next;
    logic [CNT_W-1:0]             used_cnt_reg, used_cnt_next;
    logic [bpl_pkg::CAP_W-1:0]    cap_reg;
    bpl_pkg::rsp_t                res_reg, res_next;

    logic [CMP_W-1:0]             cap_cmp;
    logic [CMP_W-1:0]             eff_cap;
    logic                         room;
    logic                         scan_last;
    logic                         rm_done;
    logic [IDX_W+3:0]             tgt_ext;
    logic [bpl_pkg::PIN_W-1:0]    dec_pins;

    // Clamp the capacity register to 1..SLOTS
    assign cap_cmp = CMP_W'(cap_reg);
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_cmp > SLOTS_CMP)
        begin
            eff_cap = SLOTS_CMP;
        end
        else
        begin
            eff_cap = cap_cmp;
        end
    end

    assign room      = (CMP_W'(used_cnt_reg) < eff_cap) && free_found_reg;
    assign scan_last = rd_pend_reg && (rd_idx_reg == LAST_IDX);
    assign rm_done   = (rm_i_reg == unpin_cnt_reg) && !rm_pend_reg;
    assign tgt_ext   = {4'b0, tgt_reg};
    assign dec_pins  = hit_pins_reg - 16'd1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpl_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = bpl_pkg::S_SCAN;
                end
            end
            bpl_pkg::S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = bpl_pkg::S_DECIDE;
                end
            end
            bpl_pkg::S_DECIDE:
            begin
                if (action_reg == bpl_pkg::ACT_UNFIX)
                begin
                    state_next = bpl_pkg::S_DONE;
                end
                else if (hit_reg)
                begin
                    if (hit_pins_reg == bpl_pkg::PIN_MAX)
                    begin
                        state_next = bpl_pkg::S_DONE;
                    end
                    else if (hit_pins_reg == '0)
                    begin
                        state_next = bpl_pkg::S_RMV;
                    end
                    else
                    begin
                        state_next = bpl_pkg::S_WRITE;
                    end
                end
                else if (room)
                begin
                    state_next = bpl_pkg::S_WRITE;
                end
                else if (unpin_cnt_reg == '0)
                begin
                    state_next = bpl_pkg::S_DONE;
                end
                else
                begin
                    state_next = bpl_pkg::S_EVRD;
                end
            end
            bpl_pkg::S_EVRD:  state_next = bpl_pkg::S_EVTAG;
            bpl_pkg::S_EVTAG: state_next = bpl_pkg::S_RMV;
            bpl_pkg::S_RMV:
            begin
                if (rm_done)
                begin
                    state_next = bpl_pkg::S_WRITE;
                end
            end
            bpl_pkg::S_WRITE: state_next = bpl_pkg::S_DONE;
            bpl_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = bpl_pkg::S_IDLE;
                end
            end
            default: state_next = bpl_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory commands
    always_comb
    begin
        action_next     = action_reg;
        id_next         = id_reg;
        scan_addr_next  = scan_addr_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_next        = hit_reg;
        hit_pins_next   = hit_pins_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        tgt_next        = tgt_reg;
        ev_next         = ev_reg;
        evid_next       = evid_reg;
        load_free_next  = load_free_reg;
        new_pins_next   = new_pins_reg;
        rm_i_next       = rm_i_reg;
        rm_j_next       = rm_j_reg;
        rm_pend_next    = 1'b0;
        unpin_cnt_next  = unpin_cnt_reg;
        used_cnt_next   = used_cnt_reg;
        res_next        = res_reg;
        req_ready       = 1'b0;
        res_valid       = 1'b0;
        sm_we           = 1'b0;
        sm_set_valid    = 1'b0;
        sm_waddr        = tgt_reg;
        sm_wtag         = id_reg;
        sm_wpins        = new_pins_reg;
        sm_raddr        = scan_addr_reg[IDX_W-1:0];
        om_we           = 1'b0;
        om_waddr        = rm_j_reg[IDX_W-1:0];
        om_wdata        = om_rdata;
        om_raddr        = rm_i_reg[IDX_W-1:0];

        case (state_reg)
            bpl_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    action_next     = req_action;
                    id_next         = req_blk_id;
                    scan_addr_next  = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    ev_next         = 1'b0;
                    evid_next       = '0;
                    load_free_next  = 1'b0;
                end
            end
            bpl_pkg::S_SCAN:
            begin
                // Issue the next tag read
                if (scan_addr_reg < SLOTS_C)
                begin
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                // Check returning entry for a match or a free slot
                if (rd_pend_reg)
                begin
                    if (sm_rvalid && (sm_rtag == id_reg) && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        tgt_next      = rd_idx_reg;
                        hit_pins_next = sm_rpins;
                    end
                    if (!sm_rvalid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
            end
            bpl_pkg::S_DECIDE:
            begin
                res_next = '{status: bpl_pkg::ST_POOL_FULL, slot: '0, evicted: 1'b0,
                             evicted_id: '0, pin_count: '0};
                rm_i_next = '0;
                rm_j_next = '0;
                if (action_reg == bpl_pkg::ACT_UNFIX)
                begin
                    if (!hit_reg)
                    begin
                        res_next.status = bpl_pkg::ST_NOT_CACHED;
                    end
                    else if (hit_pins_reg == '0)
                    begin
                        res_next.status = bpl_pkg::ST_NO_PINS;
                    end
                    else
                    begin
                        // Drop one pin; append to the order at zero
                        sm_we    = 1'b1;
                        sm_wpins = dec_pins;
                        if ((dec_pins == '0) && (unpin_cnt_reg < SLOTS_C))
                        begin
                            om_we          = 1'b1;
                            om_waddr       = unpin_cnt_reg[IDX_W-1:0];
                            om_wdata       = tgt_reg;
                            unpin_cnt_next = unpin_cnt_reg + 1'b1;
                        end
                        res_next.status    = bpl_pkg::ST_UNFIXED;
                        res_next.slot      = tgt_ext[3:0];
                        res_next.pin_count = dec_pins;
                    end
                end
                else if (hit_reg)
                begin
                    if (hit_pins_reg == bpl_pkg::PIN_MAX)
                    begin
                        res_next.status    = bpl_pkg::ST_PIN_OVF;
                        res_next.pin_count = bpl_pkg::PIN_MAX;
                    end
                    new_pins_next = hit_pins_reg + 16'd1;
                end
                else if (room)
                begin
                    tgt_next       = free_idx_reg;
                    load_free_next = 1'b1;
                    new_pins_next  = 16'd1;
                end
                else
                begin
                    // Fetch the head of the unpinned order
                    om_raddr      = '0;
                    new_pins_next = 16'd1;
                end
            end
            bpl_pkg::S_EVRD:
            begin
                tgt_next = om_rdata;
                sm_raddr = om_rdata;
            end
            bpl_pkg::S_EVTAG:
            begin
                ev_next   = 1'b1;
                evid_next = sm_rtag;
            end
            bpl_pkg::S_RMV:
            begin
                // Compact the order, skipping the target slot
                if (rm_i_reg < unpin_cnt_reg)
                begin
                    rm_pend_next = 1'b1;
                    rm_i_next    = rm_i_reg + 1'b1;
                end
                if (rm_pend_reg && (om_rdata != tgt_reg))
                begin
                    om_we     = 1'b1;
                    rm_j_next = rm_j_reg + 1'b1;
                end
                if (rm_done)
                begin
                    unpin_cnt_next = rm_j_reg;
                end
            end
            bpl_pkg::S_WRITE:
            begin
                sm_we        = 1'b1;
                sm_set_valid = load_free_reg;
                if (load_free_reg)
                begin
                    used_cnt_next = used_cnt_reg + 1'b1;
                end
                res_next.status     = hit_reg ? bpl_pkg::ST_HIT : bpl_pkg::ST_LOADED;
                res_next.slot       = tgt_ext[3:0];
                res_next.evicted    = ev_reg;
                res_next.evicted_id = evid_reg;
                res_next.pin_count  = new_pins_reg;
            end
            bpl_pkg::S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpl_pkg::S_IDLE;
            rd_pend_reg   <= 1'b0;
            rm_pend_reg   <= 1'b0;
            unpin_cnt_reg <= '0;
            used_cnt_reg  <= '0;
            cap_reg       <= bpl_pkg::CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            rm_pend_reg   <= rm_pend_next;
            unpin_cnt_reg <= unpin_cnt_next;
            used_cnt_reg  <= used_cnt_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        id_reg         <= id_next;
        scan_addr_reg  <= scan_addr_next;
        rd_idx_reg     <= rd_idx_next;
        hit_reg        <= hit_next;
        hit_pins_reg   <= hit_pins_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        tgt_reg        <= tgt_next;
        ev_reg         <= ev_next;
        evid_reg       <= evid_next;
        load_free_reg  <= load_free_next;
        new_pins_reg   <= new_pins_next;
        rm_i_reg       <= rm_i_next;
        rm_j_reg       <= rm_j_next;
        res_reg        <= res_next;
    end

    assign res = res_reg;

endmodule

// File: rtl/core/buffer_pool_fix_unfix_lru.sv
// Top level of the buffer pool slot manager with pin counts and LRU replacement.
//
// Requests arrive on req (valid/ready): action 0 fixes blk_id, action 1 unfixes
// it. Each request gives exactly one response on rsp (valid/ready) with status,
// slot, evicted, evicted_id and the resulting pin_count.
// The pool size in use is set by cfg_we/cfg_wdata while no request is in flight;
// a value of 0 acts as 1 and values above SLOTS act as SLOTS.
// Per request the sequencer scans all SLOTS entries of the slot memory through
// its one read port, decides, and for a fix of an unpinned slot or an eviction
// compacts the unpinned order memory (after fetching the victim through S_EVRD
// and S_EVTAG), then writes back in S_WRITE and presents the result in S_DONE.
// A request is taken only while the sequencer is idle; the response sits in an
// output register, so the next request starts while the previous response waits.
// When the receiver stalls, a finished result is held inside the sequencer until
// the output register frees up.
// Reset clears all valid flags, counts and the pool size (back to 16); tags and
// the order memory need no clearing pass, so requests are accepted right away.
module buffer_pool_fix_unfix_lru #(
    parameter int SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bpl_req_if.sink                     req,
    bpl_rsp_if.source                   rsp,
    input  logic                        cfg_we,
    input  logic [bpl_pkg::CAP_W-1:0]   cfg_wdata
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic                       res_valid;
    logic                       res_ready;
    bpl_pkg::rsp_t              res;
    logic                       sm_we;
    logic                       sm_set_valid;
    logic [IDX_W-1:0]           sm_waddr;
    logic [bpl_pkg::ID_W-1:0]   sm_wtag;
    logic [bpl_pkg::PIN_W-1:0]  sm_wpins;
    logic [IDX_W-1:0]           sm_raddr;
    logic                       sm_rvalid;
    logic [bpl_pkg::ID_W-1:0]   sm_rtag;
    logic [bpl_pkg::PIN_W-1:0]  sm_rpins;
    logic                       om_we;
    logic [IDX_W-1:0]           om_waddr;
    logic [IDX_W-1:0]           om_wdata;
    logic [IDX_W-1:0]           om_raddr;
    logic [IDX_W-1:0]           om_rdata;

    logic                       out_valid_reg;
    bpl_pkg::rsp_t              out_reg;

    bpl_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req.valid),
        .req_action   (req.action),
        .req_blk_id   (req.blk_id),
        .req_ready    (req.ready),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .sm_we        (sm_we),
        .sm_set_valid (sm_set_valid),
        .sm_waddr     (sm_waddr),
        .sm_wtag      (sm_wtag),
        .sm_wpins     (sm_wpins),
        .sm_raddr     (sm_raddr),
        .sm_rvalid    (sm_rvalid),
        .sm_rtag      (sm_rtag),
        .sm_rpins     (sm_rpins),
        .om_we        (om_we),
        .om_waddr     (om_waddr),
        .om_wdata     (om_wdata),
        .om_raddr     (om_raddr),
        .om_rdata     (om_rdata)
    );

    bpl_slot_store #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_slot_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .we        (sm_we),
        .set_valid (sm_set_valid),
        .waddr     (sm_waddr),
        .wtag      (sm_wtag),
        .wpins     (sm_wpins),
        .raddr     (sm_raddr),
        .rvalid    (sm_rvalid),
        .rtag      (sm_rtag),
        .rpins     (sm_rpins)
    );

    bpl_order_store #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_order_store (
        .clk   (clk),
        .we    (om_we),
        .waddr (om_waddr),
        .wdata (om_wdata),
        .raddr (om_raddr),
        .rdata (om_rdata)
    );

    // Take a result when the output register is empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    // Hold the response until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.slot       = out_reg.slot;
    assign rsp.evicted    = out_reg.evicted;
    assign rsp.evicted_id = out_reg.evicted_id;
    assign rsp.pin_count  = out_reg.pin_count;

endmodule

// File: tb/tb_buffer_pool_fix_unfix_lru.sv
// Self-checking testbench for the buffer pool slot manager with pin counts and LRU eviction.
`timescale 1ns / 100ps

module tb_buffer_pool_fix_unfix_lru;

    localparam int SLOTS   = 16;
    localparam int HOT_IDS = 24;
    localparam int ID_W    = bpl_pkg::ID_W;
    localparam int PIN_W   = bpl_pkg::PIN_W;
    localparam int SLOT_W  = bpl_pkg::SLOT_W;
    localparam int CAP_W   = bpl_pkg::CAP_W;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    bpl_req_if req_ch ();
    bpl_rsp_if rsp_ch ();

    buffer_pool_fix_unfix_lru #(
        .SLOTS(SLOTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the pool: slot table, unpinned order and pool size
    logic             pool_valid [SLOTS];
    logic [ID_W-1:0]  pool_tag   [SLOTS];
    logic [PIN_W-1:0] pool_pins  [SLOTS];
    int               lru_list   [SLOTS];
    int               lru_len;
    int               pool_used;
    logic [CAP_W-1:0] pool_cap;

    bpl_pkg::rsp_t pending_results [$];

    logic [ID_W-1:0]  hot_ids  [HOT_IDS];
    logic [CAP_W-1:0] cap_plan [10] = '{5'd16, 5'd4, 5'd1, 5'd8, 5'd31,
                                        5'd0, 5'd3, 5'd12, 5'd17, 5'd2};

    bit idle_on;
    int hold_left;
    int stall_left;
    int fail_count;
    int requests_sent;
    int evictions;
    int status_seen [8];

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Drop a slot from the unpinned order, keeping the rest in sequence
    function automatic void lru_drop(input int victim);
        int j;
        j = 0;
        for (int i = 0; i < lru_len; i++)
        begin
            if (lru_list[i] != victim)
            begin
                lru_list[j] = lru_list[i];
                j++;
            end
        end
        lru_len = j;
    endfunction

    // Apply one fix or unfix to the shadow pool and return the response it must give
    function automatic bpl_pkg::rsp_t resolve_request(input logic act,
                                                      input logic [ID_W-1:0] id);
        bpl_pkg::rsp_t r;
        int   hit_slot;
        int   target;
        int   eff;
        r = '0;
        hit_slot = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (pool_valid[i] && pool_tag[i] == id)
                hit_slot = i;
        end
        eff = (pool_cap == 0) ? 1 : ((pool_cap > SLOTS) ? SLOTS : int'(pool_cap));

        if (act == bpl_pkg::ACT_FIX)
        begin
            if (hit_slot < SLOTS)
            begin
                if (pool_pins[hit_slot] == bpl_pkg::PIN_MAX)
                begin
                    r.status    = bpl_pkg::ST_PIN_OVF;
                    r.pin_count = bpl_pkg::PIN_MAX;
                end
                else
                begin
                    // a pinned slot leaves the eviction order
                    if (pool_pins[hit_slot] == 0)
                        lru_drop(hit_slot);
                    pool_pins[hit_slot] = pool_pins[hit_slot] + 1'b1;
                    r.status    = bpl_pkg::ST_HIT;
                    r.slot      = hit_slot[SLOT_W-1:0];
                    r.pin_count = pool_pins[hit_slot];
                end
            end
            else
            begin
                // lowest free slot while below the pool size, else the oldest unpinned
                target = SLOTS;
                if (pool_used < eff)
                begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                    begin
                        if (!pool_valid[i])
                            target = i;
                    end
                end
                if (target == SLOTS && lru_len == 0)
                    r.status = bpl_pkg::ST_POOL_FULL;
                else
                begin
                    if (target == SLOTS)
                    begin
                        target = lru_list[0];
                        lru_drop(target);
                        r.evicted    = 1'b1;
                        r.evicted_id = pool_tag[target];
                    end
                    else
                    begin
                        pool_valid[target] = 1'b1;
                        pool_used++;
                    end
                    pool_tag[target]  = id;
                    pool_pins[target] = 1;
                    r.status    = bpl_pkg::ST_LOADED;
                    r.slot      = target[SLOT_W-1:0];
                    r.pin_count = 1;
                end
            end
        end
        else if (hit_slot == SLOTS)
            r.status = bpl_pkg::ST_NOT_CACHED;
        else if (pool_pins[hit_slot] == 0)
            r.status = bpl_pkg::ST_NO_PINS;
        else
        begin
            pool_pins[hit_slot] = pool_pins[hit_slot] - 1'b1;
            if (pool_pins[hit_slot] == 0 && lru_len < SLOTS)
            begin
                lru_list[lru_len] = hit_slot;
                lru_len++;
            end
            r.status    = bpl_pkg::ST_UNFIXED;
            r.slot      = hit_slot[SLOT_W-1:0];
            r.pin_count = pool_pins[hit_slot];
        end
        return r;
    endfunction

    // Offer one request, hold it until taken, then record the expected response
    task automatic issue_request(input logic act, input logic [ID_W-1:0] id);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.blk_id <= id;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_results.insert(pending_results.size(), resolve_request(act, id));
        requests_sent++;
        @(negedge clk);
    endtask

    // Drain the block, let the sequencer settle, then set the pool size
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        pool_cap = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Walk through misses, hits, errors, eviction order and odd pool sizes
    task automatic run_directed();
        idle_on = 1'b1;
        issue_request(bpl_pkg::ACT_UNFIX, 32'h0000_0000);    // nothing cached yet
        issue_request(bpl_pkg::ACT_FIX, 32'h0000_0000);
        issue_request(bpl_pkg::ACT_FIX, 32'hFFFF_FFFF);
        issue_request(bpl_pkg::ACT_FIX, 32'h0000_0000);      // hit, second pin
        issue_request(bpl_pkg::ACT_UNFIX, 32'h0000_0000);
        issue_request(bpl_pkg::ACT_UNFIX, 32'h0000_0000);    // count reaches zero
        issue_request(bpl_pkg::ACT_UNFIX, 32'h0000_0000);    // already at zero pins
        issue_request(bpl_pkg::ACT_UNFIX, 32'hFFFF_FFFF);
        issue_request(bpl_pkg::ACT_FIX, 32'h0000_0000);      // hit pulls slot out of order
        write_capacity(5'd2);
        issue_request(bpl_pkg::ACT_FIX, 32'h5A5A_5A5A);      // evicts the all-ones block
        issue_request(bpl_pkg::ACT_FIX, 32'h1234_5678);      // every slot pinned
        issue_request(bpl_pkg::ACT_UNFIX, 32'h0000_0000);
        issue_request(bpl_pkg::ACT_UNFIX, 32'h5A5A_5A5A);
        issue_request(bpl_pkg::ACT_FIX, 32'h1234_5678);
        // pool size below slots in use, zero acting as one
        write_capacity(5'd0);
        issue_request(bpl_pkg::ACT_FIX, 32'hCAFE_0001);
        issue_request(bpl_pkg::ACT_FIX, 32'hCAFE_0002);
        // oversized value acts as the full pool
        write_capacity(5'd31);
        issue_request(bpl_pkg::ACT_FIX, 32'hCAFE_0002);
        issue_request(bpl_pkg::ACT_UNFIX, 32'h1234_5678);
        issue_request(bpl_pkg::ACT_FIX, 32'h8000_0000);      // free slot wins over eviction
    endtask

    // Block the response side long enough for the request side to stall
    task automatic run_backpressure();
        write_capacity(5'd16);
        hold_left = 300;
        for (int i = 0; i < 16; i++)
            issue_request(bpl_pkg::ACT_FIX, $urandom());
    endtask

    // Mostly fixes and unfixes over a small hot set, with a little random noise
    task automatic run_random_mix();
        int r;
        int span;
        int eff;
        for (int i = 0; i < HOT_IDS; i++)
            hot_ids[i] = $urandom();
        for (int seg = 0; seg < 10; seg++)
        begin
            write_capacity((seg == 9) ? CAP_W'($urandom_range(0, 31)) : cap_plan[seg]);
            idle_on = (seg % 3 != 2);
            for (int i = 0; i < 4; i++)
                hot_ids[$urandom_range(0, HOT_IDS - 1)] = $urandom();
            eff = (pool_cap == 0) ? 1 : ((pool_cap > SLOTS) ? SLOTS : int'(pool_cap));
            span = (eff + 4 > HOT_IDS) ? HOT_IDS : eff + 4;
            for (int n = 0; n < 100; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    issue_request(r[0] ? bpl_pkg::ACT_UNFIX : bpl_pkg::ACT_FIX, $urandom());
                else if (r < 55)
                    issue_request(bpl_pkg::ACT_FIX, hot_ids[$urandom_range(0, span - 1)]);
                else
                    issue_request(bpl_pkg::ACT_UNFIX, hot_ids[$urandom_range(0, span - 1)]);
            end
        end
    endtask

    // Pin and unpin one block back to back down past zero, no idling
    task automatic run_closing_burst();
        logic [ID_W-1:0] id;
        write_capacity(5'd16);
        idle_on = 1'b0;
        id = hot_ids[0];
        for (int i = 0; i < 6; i++)
            issue_request(bpl_pkg::ACT_FIX, id);
        for (int i = 0; i < 8; i++)
            issue_request(bpl_pkg::ACT_UNFIX, id);
        issue_request(bpl_pkg::ACT_FIX, 32'h0BAD_F00D);
    endtask

    // Response side readiness: long hold-offs, random stall bursts, otherwise ready
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 10);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted response with the oldest expectation
    always @(posedge clk)
    begin
        bpl_pkg::rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            status_seen[rsp_ch.status]++;
            if (rsp_ch.evicted)
                evictions++;
            if (pending_results.size() == 0)
            begin
                $error("response with no request outstanding: status %0d", rsp_ch.status);
                fail_count++;
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, rsp_ch.slot);
                    fail_count++;
                end
                if (rsp_ch.evicted !== want.evicted)
                begin
                    $error("evicted: expected %0d, got %0d", want.evicted, rsp_ch.evicted);
                    fail_count++;
                end
                if (rsp_ch.evicted_id !== want.evicted_id)
                begin
                    $error("evicted_id: expected %h, got %h", want.evicted_id,
                           rsp_ch.evicted_id);
                    fail_count++;
                end
                if (rsp_ch.pin_count !== want.pin_count)
                begin
                    $error("pin_count: expected %0d, got %0d", want.pin_count,
                           rsp_ch.pin_count);
                    fail_count++;
                end
            end
        end
    end

    // Sequence the tests and report
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        req_ch.valid  = 1'b0;
        req_ch.action = bpl_pkg::ACT_FIX;
        req_ch.blk_id = '0;
        idle_on       = 1'b0;
        hold_left     = 0;
        stall_left    = 0;
        fail_count    = 0;
        requests_sent = 0;
        evictions     = 0;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            pool_valid[i] = 1'b0;
            pool_pins[i]  = '0;
        end
        lru_len   = 0;
        pool_used = 0;
        pool_cap  = bpl_pkg::CAP_RESET;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_backpressure();
        run_random_mix();
        run_closing_burst();

        // wait out the remaining responses
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2 * SLOTS + 10) @(negedge clk);

        $display("Ran %0d requests: directed cases, back-pressure, ten pool sizes, final burst",
                 requests_sent);
        $display("Seen: hit %0d loaded %0d evict %0d full %0d unfix %0d miss %0d zero %0d ovf %0d",
                 status_seen[bpl_pkg::ST_HIT], status_seen[bpl_pkg::ST_LOADED], evictions,
                 status_seen[bpl_pkg::ST_POOL_FULL], status_seen[bpl_pkg::ST_UNFIXED],
                 status_seen[bpl_pkg::ST_NOT_CACHED], status_seen[bpl_pkg::ST_NO_PINS],
                 status_seen[bpl_pkg::ST_PIN_OVF]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Run timed out with %0d responses outstanding", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
